// ===== hw/rtl/lwcs_pkg.sv =====
// Shared types and constants for the LCD window command sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lwcs_pkg;

    // Display controller command codes
    localparam logic [15:0] CMD_COLUMN_SET   = 16'h002A;
    localparam logic [15:0] CMD_PAGE_SET     = 16'h002B;
    localparam logic [15:0] CMD_MEMORY_WRITE = 16'h002C;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SIZE  = 2'd1;
    localparam logic [1:0] STATUS_SHAPE = 2'd2;

    // Request mode codes
    localparam logic MODE_WINDOW = 1'b0;
    localparam logic MODE_PIXEL  = 1'b1;

    // Entries held between the front and the back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        mode;
        logic [15:0] x_left;
        logic [15:0] y_top;
        logic [15:0] win_width;
        logic [15:0] win_height;
        logic [15:0] pixel_colour;
    } req_t;

    typedef struct packed {
        logic        is_data;
        logic [15:0] bus_word;
        logic        last;
        logic [1:0]  status;
    } word_t;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_WINDOW = 2'd2
    } kind_t;

    // One classified request as carried from front to back
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  status;
        logic [15:0] colour;
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] bottom;
    } entry_t;

endpackage : lwcs_pkg

`default_nettype wire

// ===== hw/rtl/lwcs_front.sv =====
// Front end: accepts requests, computes window corners and classifies them.
`timescale 1ns / 1ps
`default_nettype none

module lwcs_front
    import lwcs_pkg::*;
#(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  wire logic   req_valid,
    output logic        req_ready,
    input  wire req_t   req_data,
    input  wire logic   queue_full,
    output logic        push,
    output entry_t      entry
);

    localparam logic [16:0] PanelW = 17'(PANEL_WIDTH);
    localparam logic [16:0] PanelH = 17'(PANEL_HEIGHT);

    logic [16:0] sum_x;
    logic [16:0] sum_y;
    logic [16:0] right;
    logic [16:0] bottom;
    logic        size_err;
    logic        shape_err;

    assign req_ready = !queue_full;
    assign push      = req_valid && !queue_full;

    // A zero sum wraps the corner to a huge value, which is a size error
    assign sum_x  = {1'b0, req_data.x_left} + {1'b0, req_data.win_width};
    assign sum_y  = {1'b0, req_data.y_top} + {1'b0, req_data.win_height};
    assign right  = sum_x - 17'd1;
    assign bottom = sum_y - 17'd1;

    assign size_err = (sum_x == 17'd0) || (right >= PanelW)
                   || (sum_y == 17'd0) || (bottom >= PanelH);
    assign shape_err = ({1'b0, req_data.x_left} > right)
                    || ({1'b0, req_data.y_top} > bottom);

    always_comb
    begin
        entry.colour = req_data.pixel_colour;
        entry.left   = req_data.x_left;
        entry.right  = right[15:0];
        entry.top    = req_data.y_top;
        entry.bottom = bottom[15:0];
        if (req_data.mode == MODE_PIXEL)
        begin
            entry.kind   = KIND_PIXEL;
            entry.status = STATUS_OK;
        end
        else if (size_err)
        begin
            entry.kind   = KIND_ERROR;
            entry.status = STATUS_SIZE;
        end
        else if (shape_err)
        begin
            entry.kind   = KIND_ERROR;
            entry.status = STATUS_SHAPE;
        end
        else
        begin
            entry.kind   = KIND_WINDOW;
            entry.status = STATUS_OK;
        end
    end

endmodule : lwcs_front

`default_nettype wire

// ===== hw/rtl/lwcs_queue.sv =====
// Short FIFO of classified entries between front and back.
`timescale 1ns / 1ps
`default_nettype none

module lwcs_queue
    import lwcs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output entry_t      head
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    entry_t            mem [QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;

    assign full  = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PtrW'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PtrW'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule : lwcs_queue

`default_nettype wire

// ===== hw/rtl/lwcs_back.sv =====
// Back end: expands queued entries into bus words behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module lwcs_back
    import lwcs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   queue_empty,
    input  wire entry_t head,
    output logic        pop,
    output logic        word_valid,
    input  wire logic   word_ready,
    output word_t       word_data
);

    localparam logic [3:0] STEP_COL_CMD  = 4'd0;
    localparam logic [3:0] STEP_COL_SH   = 4'd1;
    localparam logic [3:0] STEP_COL_SL   = 4'd2;
    localparam logic [3:0] STEP_COL_EH   = 4'd3;
    localparam logic [3:0] STEP_COL_EL   = 4'd4;
    localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
    localparam logic [3:0] STEP_PAGE_SH  = 4'd6;
    localparam logic [3:0] STEP_PAGE_SL  = 4'd7;
    localparam logic [3:0] STEP_PAGE_EH  = 4'd8;
    localparam logic [3:0] STEP_PAGE_EL  = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD  = 4'd10;

    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       valid_reg;
    logic       valid_next;
    word_t      word_reg;
    word_t      word_next;
    logic       load;
    logic       word_last;

    assign load      = !queue_empty && (!valid_reg || word_ready);
    assign word_last = (head.kind != KIND_WINDOW) || (step_reg == STEP_MEM_CMD);
    assign pop       = load && word_last;

    assign word_valid = valid_reg;
    assign word_data  = word_reg;

    always_comb
    begin
        word_next.last   = 1'b0;
        word_next.status = head.status;
        word_next.is_data  = 1'b1;
        word_next.bus_word = 16'h0000;
        unique case (head.kind)
            KIND_PIXEL:
            begin
                word_next.bus_word = head.colour;
                word_next.last     = 1'b1;
            end
            KIND_ERROR:
            begin
                word_next.is_data = 1'b0;
                word_next.last    = 1'b1;
            end
            KIND_WINDOW:
            begin
                unique case (step_reg)
                    STEP_COL_CMD:
                    begin
                        word_next.is_data  = 1'b0;
                        word_next.bus_word = CMD_COLUMN_SET;
                    end
                    STEP_COL_SH:   word_next.bus_word = {8'h00, head.left[15:8]};
                    STEP_COL_SL:   word_next.bus_word = {8'h00, head.left[7:0]};
                    STEP_COL_EH:   word_next.bus_word = {8'h00, head.right[15:8]};
                    STEP_COL_EL:   word_next.bus_word = {8'h00, head.right[7:0]};
                    STEP_PAGE_CMD:
                    begin
                        word_next.is_data  = 1'b0;
                        word_next.bus_word = CMD_PAGE_SET;
                    end
                    STEP_PAGE_SH:  word_next.bus_word = {8'h00, head.top[15:8]};
                    STEP_PAGE_SL:  word_next.bus_word = {8'h00, head.top[7:0]};
                    STEP_PAGE_EH:  word_next.bus_word = {8'h00, head.bottom[15:8]};
                    STEP_PAGE_EL:  word_next.bus_word = {8'h00, head.bottom[7:0]};
                    STEP_MEM_CMD:
                    begin
                        word_next.is_data  = 1'b0;
                        word_next.bus_word = CMD_MEMORY_WRITE;
                        word_next.last     = 1'b1;
                    end
                    default:
                    begin
                        word_next.is_data  = 1'b0;
                        word_next.bus_word = 16'h0000;
                    end
                endcase
            end
            default:
            begin
                word_next.is_data = 1'b0;
                word_next.last    = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = word_last ? STEP_COL_CMD : step_reg + 4'd1;
        end
        else if (word_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_COL_CMD;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule : lwcs_back

`default_nettype wire

// ===== hw/rtl/lcd_window_command_sequencer_unit.sv =====
// Top level of the LCD window command sequencer: front, entry queue and back.
// A request's first word passes through the entry queue, then the back end's output register.
// Throughput: one bus word per cycle while the receiver is ready; a pixel expands to
// one word, a window to eleven, through the back end's single output register.
// Requests keep arriving while a window expands until the four-entry queue fills.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module lcd_window_command_sequencer_unit
    import lwcs_pkg::*;
#(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_ready,
    input  wire req_t   req_data,
    output logic        word_valid,
    input  wire logic   word_ready,
    output word_t       word_data
);

    // Front to queue
    logic   push;
    entry_t push_entry;

    // Queue to back
    logic   queue_full;
    logic   queue_empty;
    logic   pop;
    entry_t head;

    // Classify each request the cycle it is accepted; hold off only when
    // the queue is full.
    lwcs_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    // Decouple the front from the back so a window burst does not stall
    // the request side until the queue fills.
    lwcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    // Expand the head entry into bus words; drop it after its last word.
    lwcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .word_data   (word_data)
    );

endmodule : lcd_window_command_sequencer_unit

`default_nettype wire

// ===== verif/lwcs_bus_checker.sv =====
// Checker for the LCD window command sequencer: predicts every bus word and compares it.
`timescale 1ns / 1ps

module lwcs_bus_checker
    import lwcs_pkg::*;
#(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    input  wire logic  req_ready,
    input  wire req_t  req_data,
    input  wire logic  word_valid,
    input  wire logic  word_ready,
    input  wire word_t word_data,
    output int         errors,
    output int         pending
);

    // Bus words still owed by the block, oldest first
    word_t bus_expect[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic void push_word(input logic is_data, input logic [15:0] value,
                                      input logic last, input logic [1:0] status);
        word_t w;
        w.is_data  = is_data;
        w.bus_word = value;
        w.last     = last;
        w.status   = status;
        bus_expect.push_back(w);
    endfunction

    // Address set command followed by start and end, high byte first
    function automatic void push_range(input logic [15:0] cmd, input logic [31:0] lo,
                                       input logic [31:0] hi);
        push_word(1'b0, cmd, 1'b0, STATUS_OK);
        push_word(1'b1, {8'h00, lo[15:8]}, 1'b0, STATUS_OK);
        push_word(1'b1, {8'h00, lo[7:0]}, 1'b0, STATUS_OK);
        push_word(1'b1, {8'h00, hi[15:8]}, 1'b0, STATUS_OK);
        push_word(1'b1, {8'h00, hi[7:0]}, 1'b0, STATUS_OK);
    endfunction

    function automatic void expand_request(input req_t r);
        logic [31:0] right;
        logic [31:0] bottom;
        if (r.mode == MODE_PIXEL) begin
            push_word(1'b1, r.pixel_colour, 1'b1, STATUS_OK);
            return;
        end
        // Corners wrap modulo 2^32 when a start and its size are both zero
        right  = {16'h0000, r.x_left} + {16'h0000, r.win_width} - 32'd1;
        bottom = {16'h0000, r.y_top} + {16'h0000, r.win_height} - 32'd1;
        if (right >= PANEL_WIDTH || bottom >= PANEL_HEIGHT)
            push_word(1'b0, 16'h0000, 1'b1, STATUS_SIZE);
        else if ({16'h0000, r.x_left} > right || {16'h0000, r.y_top} > bottom)
            push_word(1'b0, 16'h0000, 1'b1, STATUS_SHAPE);
        else begin
            push_range(CMD_COLUMN_SET, {16'h0000, r.x_left}, right);
            push_range(CMD_PAGE_SET, {16'h0000, r.y_top}, bottom);
            push_word(1'b0, CMD_MEMORY_WRITE, 1'b1, STATUS_OK);
        end
    endfunction

    always @(posedge clk) begin : watch
        word_t want;
        if (rst_n) begin
            // Check the word before adding this edge's request, so a stray word
            // never matches a prediction made in the same cycle
            if (word_valid && word_ready) begin
                if (bus_expect.size() == 0)
                    report("unexpected word", 32'(word_data), 32'd0);
                else begin
                    want = bus_expect.pop_front();
                    if (word_data.is_data !== want.is_data)
                        report("is_data", 32'(word_data.is_data), 32'(want.is_data));
                    if (word_data.bus_word !== want.bus_word)
                        report("bus_word", 32'(word_data.bus_word), 32'(want.bus_word));
                    if (word_data.last !== want.last)
                        report("last", 32'(word_data.last), 32'(want.last));
                    if (word_data.status !== want.status)
                        report("status", 32'(word_data.status), 32'(want.status));
                end
            end
            if (req_valid && req_ready)
                expand_request(req_data);
        end
        pending <= bus_expect.size();
    end

endmodule

// ===== verif/lcd_window_command_sequencer_unit_tb.sv =====
// Top of the LCD window command sequencer testbench: clock, reset, request and word traffic.
`timescale 1ns / 1ps

module lcd_window_command_sequencer_unit_tb;
    import lwcs_pkg::*;

    localparam int PANEL_W     = 240;
    localparam int PANEL_H     = 320;
    localparam int RANDOM_REQS = 290;  // on top of the directed requests
    localparam int CALM_REQS   = 40;   // final stretch with no idling on either side
    localparam int HOLD_AT     = 80;   // random request index that triggers the long hold
    localparam int HOLD_CYCLES = 60;   // long receiver hold, well past the queue depth
    localparam int DRAIN       = 20;   // drain margin after the last expected word; leave generous margin

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  req_valid  = 1'b0;
    req_t  req_data   = '0;
    logic  req_ready;
    logic  word_valid;
    logic  word_ready = 1'b0;
    word_t word_data;

    int errors;
    int pending;
    bit calm    = 1'b0;  // set for the last requests: no gaps, no stalls
    bit hold_due = 1'b0; // asks the word side for its single long hold

    // 12 ns period
    always #6 clk = ~clk;

    lcd_window_command_sequencer_unit #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .word_valid(word_valid),
        .word_ready(word_ready),
        .word_data (word_data)
    );

    lwcs_bus_checker #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .word_valid(word_valid),
        .word_ready(word_ready),
        .word_data (word_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Pixel request; the window fields carry random noise the block must ignore
    function automatic req_t pixel(input logic [15:0] colour);
        req_t r;
        r.mode         = MODE_PIXEL;
        r.x_left       = 16'($urandom);
        r.y_top        = 16'($urandom);
        r.win_width    = 16'($urandom);
        r.win_height   = 16'($urandom);
        r.pixel_colour = colour;
        return r;
    endfunction

    // Window request; the colour field carries random noise
    function automatic req_t window(input logic [15:0] left, input logic [15:0] top,
                                    input logic [15:0] w, input logic [15:0] h);
        req_t r;
        r.mode         = MODE_WINDOW;
        r.x_left       = left;
        r.y_top        = top;
        r.win_width    = w;
        r.win_height   = h;
        r.pixel_colour = 16'($urandom);
        return r;
    endfunction

    // Offer one request and hold it until the block takes it. Outside the calm
    // stretch, sometimes drop valid for a random burst first.
    task automatic send(input req_t r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        // Ready is read before this edge's updates land, so the loop exits on the
        // very edge that accepted the request
        do @(posedge clk); while (!req_ready);
    endtask

    // Mostly legal windows and pixel streams, a share of shape errors, and raw
    // noise that nearly always lands on the size check
    function automatic req_t random_request();
        logic [15:0] left;
        logic [15:0] top;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return pixel(16'($urandom));
            5, 6, 7: begin
                left = 16'($urandom_range(0, PANEL_W - 1));
                top  = 16'($urandom_range(0, PANEL_H - 1));
                return window(left, top, 16'($urandom_range(1, PANEL_W - left)),
                              16'($urandom_range(1, PANEL_H - top)));
            end
            8: begin
                // Zero size away from the origin: corner lands before the start
                if ($urandom_range(0, 1) == 0)
                    return window(16'($urandom_range(1, PANEL_W)),
                                  16'($urandom_range(0, PANEL_H - 1)), 16'd0, 16'd1);
                else
                    return window(16'($urandom_range(0, PANEL_W - 1)),
                                  16'($urandom_range(1, PANEL_H)), 16'd1, 16'd0);
            end
            default: return window(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
        endcase
    endfunction

    // Word side: random stall bursts, one long hold on request, then none at the end
    initial begin : sink
        bit held;
        held = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_due && !held) begin
                // Hold off long enough for the queue to fill and back up the request side
                held = 1'b1;
                word_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                word_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            word_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pixel extremes
        send(pixel(16'h0000));
        send(pixel(16'hFFFF));
        // Legal windows: smallest, whole panel, far corner, rows past 255
        send(window(16'd0, 16'd0, 16'd1, 16'd1));
        send(window(16'd0, 16'd0, 16'(PANEL_W), 16'(PANEL_H)));
        send(window(16'(PANEL_W - 1), 16'(PANEL_H - 1), 16'd1, 16'd1));
        send(window(16'd100, 16'd200, 16'd40, 16'd100));
        // Zero size at the origin wraps the corner far past the panel
        send(window(16'd0, 16'd0, 16'd0, 16'd10));
        send(window(16'd0, 16'd0, 16'd10, 16'd0));
        send(window(16'd0, 16'd0, 16'd0, 16'd0));
        // Zero size elsewhere: start beyond end
        send(window(16'd5, 16'd0, 16'd0, 16'd10));
        send(window(16'd0, 16'd7, 16'd10, 16'd0));
        send(window(16'd5, 16'd5, 16'd0, 16'd0));
        send(window(16'(PANEL_W), 16'd0, 16'd0, 16'd1));
        send(window(16'd0, 16'(PANEL_H), 16'd1, 16'd0));
        // One past each panel edge
        send(window(16'd0, 16'd0, 16'(PANEL_W + 1), 16'd1));
        send(window(16'(PANEL_W), 16'd0, 16'd1, 16'd1));
        send(window(16'd0, 16'd0, 16'd1, 16'(PANEL_H + 1)));
        send(window(16'd0, 16'(PANEL_H - 1), 16'd1, 16'd2));
        // Width a shape error but height out of range: size check wins over shape
        send(window(16'd5, 16'(PANEL_H), 16'd0, 16'd1));
        // All fields at their maximum
        send(window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send(pixel(16'hA5A5));

        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == HOLD_AT)
                hold_due = 1'b1;
            if (i == RANDOM_REQS - CALM_REQS)
                calm = 1'b1;
            send(random_request());
        end
        req_valid <= 1'b0;

        // Let the checker's count catch up, then drain and allow for latency
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop the run if it hangs, with ample margin over the worst case
    initial begin : watchdog
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
